/* src/protobuf_wire_tokenizer_defines.svh */
// Assertion macros shared by the tokenizer modules.
`ifndef PROTOBUF_WIRE_TOKENIZER_DEFINES_SVH
`define PROTOBUF_WIRE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PWT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PWT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/pwt_pkg.sv */
// Types and constants of the protobuf wire tokenizer.
`timescale 1ns / 1ps

package pwt_pkg;

  // Widest length-delimited length that is accepted, in bits.
  localparam int LENGTH_BITS = 32;

  // Output queue depth and pointer width.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;

  // Wire types from the low three bits of a tag.
  localparam logic [2:0] WT_VARINT   = 3'd0;
  localparam logic [2:0] WT_FIXED64  = 3'd1;
  localparam logic [2:0] WT_LENDELIM = 3'd2;
  localparam logic [2:0] WT_FIXED32  = 3'd5;

  // Error codes carried in the value of an error token.
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_WIRE   = 3'd1;
  localparam logic [2:0] ERR_LONG   = 3'd2;
  localparam logic [2:0] ERR_LENGTH = 3'd3;
  localparam logic [2:0] ERR_TRUNC  = 3'd4;

  typedef enum logic [2:0] {
    PH_TAG = 3'd0,
    PH_VAR = 3'd1,
    PH_LEN = 3'd2,
    PH_PAY = 3'd3,
    PH_FIX = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_VARINT  = 3'd0,
    KIND_LENHDR  = 3'd1,
    KIND_PAYLOAD = 3'd2,
    KIND_FIXED   = 3'd3,
    KIND_END     = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [28:0]  field;
    logic [2:0]   wkind;
    logic [63:0]  value;
    logic         run_end;
  } token_t;

  // Tokens produced by one accepted word, first one in t0.
  typedef struct packed {
    logic [1:0] cnt;
    token_t     t0;
    token_t     t1;
  } tok_push_t;

endpackage

/* src/pwt_decode.sv */
// Wire-format decoder: parse state registers and per-byte token generation.
`timescale 1ns / 1ps
`include "protobuf_wire_tokenizer_defines.svh"

module pwt_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output pwt_pkg::tok_push_t push
);

  pwt_pkg::phase_t                    phase, phase_next;
  logic [63:0]                        accumulator, acc_next;
  logic [3:0]                         byte_count, byte_count_next;
  logic [28:0]                        held_field, held_field_next;
  logic [2:0]                         held_wire, held_wire_next;
  logic [pwt_pkg::LENGTH_BITS-1:0]    bytes_left, bytes_left_next;
  logic                               draining, draining_next;

  logic [3:0]   vcnt;
  logic [6:0]   vsh;
  logic [63:0]  acc_var;
  logic [2:0]   fcnt;
  logic [3:0]   fcnt_inc;
  logic [3:0]   fneed;
  logic [5:0]   fsh;
  logic [63:0]  acc_fix;
  logic [2:0]   err;
  logic         done;
  logic         data_v;
  logic         extra_v;
  pwt_pkg::token_t data_tok, extra_tok;

  function automatic pwt_pkg::token_t mk_token(pwt_pkg::kind_t kind, logic [28:0] field,
                                               logic [2:0] wkind, logic [63:0] value);
    pwt_pkg::token_t t;
    t.kind    = kind;
    t.field   = field;
    t.wkind   = wkind;
    t.value   = value;
    t.run_end = 1'b0;
    return t;
  endfunction

  // Varint byte lands seven bits at a time; the tenth byte saturates the position.
  assign vcnt    = (byte_count > 4'd9) ? 4'd9 : byte_count;
  assign vsh     = 7'(vcnt) * 7'd7;
  assign acc_var = accumulator | ({56'd0, 1'b0, in_byte[6:0]} << vsh);

  // Fixed-width bodies collect whole bytes little-endian.
  assign fcnt     = byte_count[2:0];
  assign fcnt_inc = {1'b0, fcnt} + 4'd1;
  assign fneed    = (held_wire == pwt_pkg::WT_FIXED64) ? 4'd8 : 4'd4;
  assign fsh      = {fcnt, 3'b000};
  assign acc_fix  = accumulator | ({56'd0, in_byte} << fsh);

  // Next state and tokens for the word on the input.
  always_comb begin
    phase_next      = phase;
    acc_next        = accumulator;
    byte_count_next = byte_count;
    held_field_next = held_field;
    held_wire_next  = held_wire;
    bytes_left_next = bytes_left;
    draining_next   = draining;
    err             = pwt_pkg::ERR_NONE;
    done            = 1'b0;
    data_v          = 1'b0;
    extra_v         = 1'b0;
    data_tok        = mk_token(pwt_pkg::KIND_VARINT, 29'd0, 3'd0, 64'd0);
    extra_tok       = mk_token(pwt_pkg::KIND_END, 29'd0, 3'd0, 64'd0);

    if (draining) begin
      // Drop words until the last one, which restores the reset state.
      if (in_last) begin
        phase_next      = pwt_pkg::PH_TAG;
        acc_next        = '0;
        byte_count_next = '0;
        held_field_next = '0;
        held_wire_next  = '0;
        bytes_left_next = '0;
        draining_next   = 1'b0;
      end
    end else begin
      case (phase)
        pwt_pkg::PH_TAG, pwt_pkg::PH_VAR, pwt_pkg::PH_LEN: begin
          acc_next = acc_var;
          if (in_byte[7]) begin
            if (vcnt >= 4'd9) begin
              err = pwt_pkg::ERR_LONG;
            end else begin
              byte_count_next = vcnt + 4'd1;
            end
          end else begin
            byte_count_next = '0;
            if (phase == pwt_pkg::PH_TAG) begin
              held_field_next = acc_var[31:3];
              held_wire_next  = acc_var[2:0];
              acc_next        = '0;
              case (acc_var[2:0])
                pwt_pkg::WT_VARINT:   phase_next = pwt_pkg::PH_VAR;
                pwt_pkg::WT_LENDELIM: phase_next = pwt_pkg::PH_LEN;
                pwt_pkg::WT_FIXED64,
                pwt_pkg::WT_FIXED32:  phase_next = pwt_pkg::PH_FIX;
                default:              err        = pwt_pkg::ERR_WIRE;
              endcase
            end else if (phase == pwt_pkg::PH_VAR) begin
              data_v   = 1'b1;
              data_tok = mk_token(pwt_pkg::KIND_VARINT, held_field, held_wire, acc_var);
              done     = 1'b1;
            end else begin
              // Length header: reject bits at or above the length width.
              if ((acc_var >> pwt_pkg::LENGTH_BITS) != 64'd0) begin
                err = pwt_pkg::ERR_LENGTH;
              end else begin
                data_v   = 1'b1;
                data_tok = mk_token(pwt_pkg::KIND_LENHDR, held_field, held_wire, acc_var);
                if (acc_var == 64'd0) begin
                  done = 1'b1;
                end else begin
                  bytes_left_next = acc_var[pwt_pkg::LENGTH_BITS-1:0];
                  acc_next        = '0;
                  phase_next      = pwt_pkg::PH_PAY;
                end
              end
            end
          end
        end
        pwt_pkg::PH_PAY: begin
          data_v   = 1'b1;
          data_tok = mk_token(pwt_pkg::KIND_PAYLOAD, held_field, held_wire, {56'd0, in_byte});
          if (bytes_left != '0) begin
            bytes_left_next = bytes_left - 1'b1;
          end
          if (bytes_left <= pwt_pkg::LENGTH_BITS'(1)) begin
            done = 1'b1;
          end
        end
        pwt_pkg::PH_FIX: begin
          acc_next        = acc_fix;
          byte_count_next = fcnt_inc;
          if (fcnt_inc >= fneed) begin
            data_v   = 1'b1;
            data_tok = mk_token(pwt_pkg::KIND_FIXED, held_field, held_wire, acc_fix);
            done     = 1'b1;
          end
        end
        default: begin
          phase_next = pwt_pkg::PH_TAG;
        end
      endcase

      // A last word that leaves a field open is a truncated message.
      if (err == pwt_pkg::ERR_NONE && !done && in_last) begin
        err = pwt_pkg::ERR_TRUNC;
      end

      if (err != pwt_pkg::ERR_NONE) begin
        extra_v         = 1'b1;
        extra_tok       = mk_token(pwt_pkg::KIND_ERROR, 29'd0, 3'd0, 64'(err));
        phase_next      = pwt_pkg::PH_TAG;
        acc_next        = '0;
        byte_count_next = '0;
        held_field_next = '0;
        held_wire_next  = '0;
        bytes_left_next = '0;
        draining_next   = !in_last;
      end else if (done) begin
        phase_next      = pwt_pkg::PH_TAG;
        acc_next        = '0;
        byte_count_next = '0;
        bytes_left_next = '0;
        if (in_last) begin
          extra_v         = 1'b1;
          held_field_next = '0;
          held_wire_next  = '0;
        end
      end
    end
  end

  // Pack the tokens; the final one of the word carries run_end.
  always_comb begin
    push.cnt        = accept ? ({1'b0, data_v} + {1'b0, extra_v}) : 2'd0;
    push.t0         = data_v ? data_tok : extra_tok;
    push.t0.run_end = !(data_v && extra_v);
    push.t1         = extra_tok;
    push.t1.run_end = 1'b1;
  end

  // Parse state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= pwt_pkg::PH_TAG;
      accumulator <= '0;
      byte_count  <= '0;
      held_field  <= '0;
      held_wire   <= '0;
      bytes_left  <= '0;
      draining    <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      accumulator <= acc_next;
      byte_count  <= byte_count_next;
      held_field  <= held_field_next;
      held_wire   <= held_wire_next;
      bytes_left  <= bytes_left_next;
      draining    <= draining_next;
    end
  end

  `PWT_ASSERT_NOW(a_second_is_closing, clk, rst, push.cnt == 2'd2, push.t1.kind == pwt_pkg::KIND_ERROR || push.t1.kind == pwt_pkg::KIND_END, "second token of a word is neither error nor end")
  `PWT_ASSERT_NOW(a_drain_silent, clk, rst, accept && draining, push.cnt == 2'd0, "token produced while draining")
  `PWT_ASSERT_NEXT(a_payload_flow, clk, rst, accept && !draining && phase == pwt_pkg::PH_PAY && !in_last, phase == pwt_pkg::PH_PAY || phase == pwt_pkg::PH_TAG, "payload byte left an unexpected phase")

endmodule

/* src/pwt_outq.sv */
// Output token queue: up to two writes and one read per cycle.
`timescale 1ns / 1ps
`include "protobuf_wire_tokenizer_defines.svh"

module pwt_outq (
  input  logic               clk,
  input  logic               rst,
  input  pwt_pkg::tok_push_t push,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output pwt_pkg::token_t    out_tok
);

  pwt_pkg::token_t          mem [pwt_pkg::OQ_DEPTH];
  logic [pwt_pkg::OQ_AW-1:0] wr_ptr, rd_ptr;
  logic [pwt_pkg::OQ_AW:0]   count, count_next;
  logic                      pop;
  logic [pwt_pkg::OQ_AW-1:0] wr_ptr_1;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != '0;
  assign out_tok   = mem[rd_ptr];
  assign wr_ptr_1  = wr_ptr + 1'b1;
  // Room for the two tokens a word can produce.
  assign space     = count <= (pwt_pkg::OQ_AW + 1)'(pwt_pkg::OQ_DEPTH - 2);
  assign count_next = count + (pwt_pkg::OQ_AW + 1)'(push.cnt) - (pwt_pkg::OQ_AW + 1)'(pop);

  // Token storage.
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.t0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_1] <= push.t1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + pwt_pkg::OQ_AW'(push.cnt);
      rd_ptr <= rd_ptr + pwt_pkg::OQ_AW'(pop);
      count  <= count_next;
    end
  end

  `PWT_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= (pwt_pkg::OQ_AW + 1)'(pwt_pkg::OQ_DEPTH), "queue fill level beyond depth")
  `PWT_ASSERT_NOW(a_push_room, clk, rst, push.cnt != 2'd0, space, "tokens pushed without room for them")
  `PWT_ASSERT_NEXT(a_pop_only, clk, rst, pop && push.cnt == 2'd0, count + 1'b1 == $past(count), "fill level not reduced by a lone read")

endmodule

/* src/protobuf_wire_tokenizer.sv */
// Tokens are registered in the output queue as their word is accepted and leave in order.
// Throughput: one byte per cycle while m_tready holds and each byte gives at most one token;
// a byte that ends a message gives two tokens, as can a byte that errors, and the single
// output read per cycle then paces input through the four-entry output queue.
// Reset: synchronous, clears the parse state to expecting a tag and empties the queue.
`timescale 1ns / 1ps

module protobuf_wire_tokenizer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] msg_byte
  input  logic         s_tlast,   // msg_last
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // [28:0] field_number, [31:29] wire_kind, [95:32] token_value
  output logic [2:0]   m_tuser,   // [2:0] token_kind
  output logic         m_tlast    // run_end
);

  pwt_pkg::tok_push_t push;
  pwt_pkg::token_t    tok;
  logic               accept;

  assign accept = s_tvalid && s_tready;

  // Byte decoder.
  pwt_decode u_dec (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (s_tdata),
    .in_last (s_tlast),
    .push    (push)
  );

  // Result queue between the decoder and the output side.
  pwt_outq u_oq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_tok   (tok)
  );

  assign m_tdata = {tok.value, tok.wkind, tok.field};
  assign m_tuser = tok.kind;
  assign m_tlast = tok.run_end;

endmodule
